FILE: hw/rtl/dsd_pkg.sv
// Shared constants and lookup functions for the decimal scientific divider.
package dsd_pkg;

	localparam int unsigned MANT_W     = 30;
	localparam int unsigned EXP_IN_W   = 7;
	localparam int unsigned EXP_OUT_W  = 8;
	localparam int unsigned FRAC_W     = 32;
	localparam int unsigned WIDE_W     = 36;  // holds 2 * 10^10 and the shifted divisor
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned QUOT_W     = 4;
	localparam int unsigned SUM_W      = 31;

	localparam logic [31:0]     RECIP10    = 32'hCCCCCCCD;  // 2^35 / 10, rounded up
	localparam int unsigned     RECIP_SH   = 35;
	localparam logic [SUM_W-1:0] ROUND_ADD  = SUM_W'(32'h00000008);
	localparam logic [SUM_W-1:0] ROUND_MASK = SUM_W'(32'hFFFFFFF0);
	localparam logic [SUM_W-1:0] DIGIT_UNIT = SUM_W'(100000000);

	// 10^idx for idx 0..10
	function automatic logic [WIDE_W-1:0] pow10(input logic [DIGIT_W-1:0] idx);
		logic [WIDE_W-1:0] v;
		case (idx)
			4'd0:    v = 36'd1;
			4'd1:    v = 36'd10;
			4'd2:    v = 36'd100;
			4'd3:    v = 36'd1000;
			4'd4:    v = 36'd10000;
			4'd5:    v = 36'd100000;
			4'd6:    v = 36'd1000000;
			4'd7:    v = 36'd10000000;
			4'd8:    v = 36'd100000000;
			4'd9:    v = 36'd1000000000;
			4'd10:   v = 36'd10000000000;
			default: v = '0;
		endcase
		return v;
	endfunction

	// round(1e9 / 2^(k+1)), k counted from the fraction MSB
	function automatic logic [SUM_W-1:0] bit_weight(input logic [4:0] k);
		logic [SUM_W-1:0] w;
		case (k)
			5'd0:  w = 31'd500000000;
			5'd1:  w = 31'd250000000;
			5'd2:  w = 31'd125000000;
			5'd3:  w = 31'd62500000;
			5'd4:  w = 31'd31250000;
			5'd5:  w = 31'd15625000;
			5'd6:  w = 31'd7812500;
			5'd7:  w = 31'd3906250;
			5'd8:  w = 31'd1953125;
			5'd9:  w = 31'd976563;
			5'd10: w = 31'd488281;
			5'd11: w = 31'd244141;
			5'd12: w = 31'd122070;
			5'd13: w = 31'd61035;
			5'd14: w = 31'd30518;
			5'd15: w = 31'd15259;
			5'd16: w = 31'd7629;
			5'd17: w = 31'd3815;
			5'd18: w = 31'd1907;
			5'd19: w = 31'd954;
			5'd20: w = 31'd477;
			5'd21: w = 31'd238;
			5'd22: w = 31'd119;
			5'd23: w = 31'd60;
			5'd24: w = 31'd30;
			5'd25: w = 31'd15;
			5'd26: w = 31'd7;
			5'd27: w = 31'd4;
			5'd28: w = 31'd2;
			5'd29: w = 31'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/dsd_if.sv
// Valid/ready channel interfaces for the divider operands and result.
interface dsd_in_if import dsd_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [MANT_W-1:0]           dividend_mantissa;
	logic signed [EXP_IN_W-1:0]  dividend_exponent;
	logic [MANT_W-1:0]           divisor_mantissa;
	logic signed [EXP_IN_W-1:0]  divisor_exponent;

	modport source (
		output valid, dividend_mantissa, dividend_exponent, divisor_mantissa, divisor_exponent,
		input  ready
	);
	modport sink (
		input  valid, dividend_mantissa, dividend_exponent, divisor_mantissa, divisor_exponent,
		output ready
	);
endinterface

interface dsd_out_if import dsd_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [MANT_W-1:0]           quotient_mantissa;
	logic signed [EXP_OUT_W-1:0] quotient_exponent;
	logic                        divide_by_zero;

	modport source (
		output valid, quotient_mantissa, quotient_exponent, divide_by_zero,
		input  ready
	);
	modport sink (
		input  valid, quotient_mantissa, quotient_exponent, divide_by_zero,
		output ready
	);
endinterface

FILE: hw/rtl/decimal_scientific_divider.sv
// Decimal scientific divider: top level with sequencer and shared subtractor.
//
// A single 36-bit compare/subtract unit does, in turn, the digit count (0..10) of each
// operand's mantissa, three 32-step binary long divisions and a 4-step integer quotient,
// followed by a 32-step weighted sum into decimal and, when the integer quotient is
// nonzero, a scaling step. A zero divisor goes straight to the finish state.
// operands.ready is high only while no item is in work; the finished result sits in an
// output register, so the next item is taken while it waits to be read.
module decimal_scientific_divider import dsd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	dsd_in_if.sink        operands,
	dsd_out_if.source     result
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_COUNT  = 7'b0000010,
		S_FRAC   = 7'b0000100,
		S_QUOT   = 7'b0001000,
		S_WSUM   = 7'b0010000,
		S_SCALE  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	// which division pass the FRAC state is running
	typedef enum logic [1:0] {
		P_DIVIDEND = 2'd0,
		P_DIVISOR  = 2'd1,
		P_REMAIN   = 2'd2
	} pass_t;

	state_t                      state_q;
	pass_t                       pass_q;
	logic [4:0]                  cnt_q;
	logic                        res_valid_q;

	logic [MANT_W-1:0]           m0_q, m1_q;
	logic signed [EXP_IN_W-1:0]  e0_q, e1_q;
	logic [DIGIT_W-1:0]          d0_q, d1_q;
	logic [WIDE_W-1:0]           rem_q, den_q;
	logic [FRAC_W-1:0]           acc_q, num_q;
	logic [QUOT_W-1:0]           q_q;
	logic [SUM_W-1:0]            sum_q;
	logic [61:0]                 prod_q;
	logic                        dz_q;
	logic [MANT_W-1:0]           res_mant_q;
	logic [EXP_OUT_W-1:0]        res_exp_q;
	logic                        res_dz_q;

	logic                        accept;
	logic                        load_res;
	logic [WIDE_W-1:0]           sub_a, sub_b;
	logic [WIDE_W:0]             diff;
	logic                        ge;
	logic [FRAC_W-1:0]           frac_next;
	logic [SUM_W-1:0]            sum_next;
	logic [SUM_W-1:0]            mant_scaled;
	logic [EXP_OUT_W-1:0]        exp_next;
	logic [MANT_W-1:0]           mant_next;

	assign accept   = operands.valid && operands.ready;
	assign load_res = (state_q == S_FINISH) && (!res_valid_q || result.ready);

	// shared compare/subtract unit
	always_comb begin
		unique case (state_q)
			S_COUNT: begin
				sub_a = {{(WIDE_W-MANT_W){1'b0}}, (pass_q == P_DIVISOR) ? m1_q : m0_q};
				sub_b = pow10(cnt_q[DIGIT_W-1:0]);
			end
			S_FRAC: begin
				sub_a = {rem_q[WIDE_W-2:0], 1'b0};
				sub_b = den_q;
			end
			S_QUOT: begin
				sub_a = rem_q;
				sub_b = den_q << (~cnt_q[1:0]);  // divisor times 8, 4, 2, 1
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge        = !diff[WIDE_W];
	assign frac_next = {acc_q[FRAC_W-2:0], ge};
	assign sum_next  = acc_q[FRAC_W-1] ? sum_q + bit_weight(cnt_q) : sum_q;

	assign mant_scaled = SUM_W'(prod_q[61:RECIP_SH]) + SUM_W'(q_q) * DIGIT_UNIT;
	assign exp_next = EXP_OUT_W'({e0_q[EXP_IN_W-1], e0_q}) + EXP_OUT_W'(d0_q)
		- EXP_OUT_W'({e1_q[EXP_IN_W-1], e1_q}) - EXP_OUT_W'(d1_q)
		+ EXP_OUT_W'(q_q != '0);

	always_comb begin
		if (q_q != '0)
			mant_next = mant_scaled[MANT_W-1:0];
		else
			mant_next = sum_q[MANT_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= P_DIVIDEND;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pass_q  <= P_DIVIDEND;
						cnt_q   <= '0;
						state_q <= (operands.divisor_mantissa == '0) ? S_FINISH : S_COUNT;
					end
				end
				S_COUNT: begin
					if (ge) begin
						cnt_q <= cnt_q + 5'd1;
					end else begin
						cnt_q   <= '0;
						state_q <= S_FRAC;
					end
				end
				S_FRAC: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						case (pass_q)
							P_DIVIDEND: begin
								pass_q  <= P_DIVISOR;
								state_q <= S_COUNT;
							end
							P_DIVISOR: state_q <= S_QUOT;
							default:   state_q <= S_WSUM;
						endcase
					end
				end
				S_QUOT: begin
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= '0;
						pass_q  <= P_REMAIN;
						state_q <= S_FRAC;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_WSUM: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= (q_q != '0) ? S_SCALE : S_FINISH;
				end
				S_SCALE: state_q <= S_FINISH;
				S_FINISH: begin
					if (load_res)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					m0_q <= operands.dividend_mantissa;
					e0_q <= operands.dividend_exponent;
					m1_q <= operands.divisor_mantissa;
					e1_q <= operands.divisor_exponent;
					dz_q <= (operands.divisor_mantissa == '0);
					q_q  <= '0;
				end
			end
			S_COUNT: begin
				if (!ge) begin
					if (pass_q == P_DIVISOR)
						d1_q <= cnt_q[DIGIT_W-1:0];
					else
						d0_q <= cnt_q[DIGIT_W-1:0];
					rem_q <= sub_a;
					den_q <= sub_b;
				end
			end
			S_FRAC: begin
				acc_q <= frac_next;
				if ((cnt_q == 5'd31) && (pass_q == P_DIVISOR)) begin
					// divisor fraction with its top bit set: halve both
					if (frac_next[FRAC_W-1]) begin
						rem_q <= WIDE_W'(num_q >> 1);
						den_q <= WIDE_W'(frac_next >> 1);
					end else begin
						rem_q <= WIDE_W'(num_q);
						den_q <= WIDE_W'(frac_next);
					end
					q_q <= '0;
				end else begin
					rem_q <= ge ? diff[WIDE_W-1:0] : sub_a;
				end
				if (cnt_q == 5'd31) begin
					case (pass_q)
						P_DIVIDEND: num_q <= frac_next;
						P_REMAIN:   sum_q <= '0;
						default: ;
					endcase
				end
			end
			S_QUOT: begin
				if (ge)
					rem_q <= diff[WIDE_W-1:0];
				q_q <= {q_q[QUOT_W-2:0], ge};
			end
			S_WSUM: begin
				acc_q <= {acc_q[FRAC_W-2:0], 1'b0};
				if (cnt_q == 5'd31)
					sum_q <= (sum_next + ROUND_ADD) & ROUND_MASK;
				else
					sum_q <= sum_next;
			end
			S_SCALE: prod_q <= 62'(sum_q) * 62'(RECIP10);
			S_FINISH: begin
				if (load_res) begin
					res_dz_q   <= dz_q;
					res_mant_q <= dz_q ? '0 : mant_next;
					res_exp_q  <= dz_q ? '0 : exp_next;
				end
			end
			default: ;
		endcase
	end

	assign operands.ready           = (state_q == S_IDLE);
	assign result.valid             = res_valid_q;
	assign result.quotient_mantissa = res_mant_q;
	assign result.quotient_exponent = res_exp_q;
	assign result.divide_by_zero    = res_dz_q;

	a_zero_div_fast: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operands.divisor_mantissa == '0) |=> (state_q == S_FINISH) && dz_q)
		else $error("zero divisor did not go straight to finish");

	a_frac_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRAC) |-> (rem_q < den_q))
		else $error("long division remainder not below divisor");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WSUM) |-> (q_q <= 4'd10))
		else $error("integer quotient above ten");

	a_dz_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_dz_q |-> (res_mant_q == '0) && (res_exp_q == '0))
		else $error("divide-by-zero result carries nonzero fields");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> $stable(res_mant_q) && $stable(res_exp_q))
		else $error("pending result overwritten");

endmodule
